### rtl/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg
// Command, status and cell operation codes shared by the double-ended
// priority queue modules.
// ----------------------------------------------------------------------------
package depq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE_MIN = 2'd1,
    CMD_REMOVE_MAX = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // What every cell of one chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

endpackage

### rtl/depq_cell.sv
// ----------------------------------------------------------------------------
// depq_cell
// One slot of a sorted chain. Holds one value, reports whether it stays in
// place on an insert, and takes its new value from the insert bus or from a
// neighbor.
// ----------------------------------------------------------------------------
module depq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter bit IS_MAX     = 1'b0
) (
  input  logic                  clk,
  input  depq_pkg::cell_op_t    op,
  input  logic [DATA_WIDTH-1:0] ins_value,
  input  logic                  occ,
  input  logic                  prev_keep,
  input  logic [DATA_WIDTH-1:0] prev_value,
  input  logic [DATA_WIDTH-1:0] next_value,
  output logic                  keep,
  output logic [DATA_WIDTH-1:0] value
);
  import depq_pkg::*;

  logic [DATA_WIDTH-1:0] value_r;
  logic [DATA_WIDTH-1:0] value_nxt;
  logic                  ranks_ahead;

  // Equal values stay ahead of the new one
  assign ranks_ahead = IS_MAX ? (value_r >= ins_value) : (value_r <= ins_value);
  assign keep        = occ && ranks_ahead;
  assign value       = value_r;

  always_comb begin
    value_nxt = value_r;
    case (op)
      CELL_INSERT: begin
        if (keep) begin
          value_nxt = value_r;
        end else if (prev_keep) begin
          value_nxt = ins_value;
        end else begin
          value_nxt = prev_value;
        end
      end
      CELL_SHIFT: begin
        value_nxt = next_value;
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

### rtl/depq_chain.sv
// ----------------------------------------------------------------------------
// depq_chain
// Row of cells that keeps the held values sorted, best value in cell 0.
// An insert opens a gap at the right place, a shift drops cell 0.
// ----------------------------------------------------------------------------
module depq_chain #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter bit IS_MAX     = 1'b0
) (
  input  logic                               clk,
  input  depq_pkg::cell_op_t                 op,
  input  logic [DATA_WIDTH-1:0]              ins_value,
  input  logic [$clog2(CAPACITY+1)-1:0]      count,
  output logic [DATA_WIDTH-1:0]              head_value
);
  import depq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  keep [CAPACITY];
  logic [DATA_WIDTH-1:0] vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  occ;
    logic                  prev_keep;
    logic [DATA_WIDTH-1:0] prev_value;
    logic [DATA_WIDTH-1:0] next_value;

    assign occ = count > CNT_W'(i);

    if (i == 0) begin : g_first
      assign prev_keep  = 1'b1;
      assign prev_value = ins_value;
    end else begin : g_mid
      assign prev_keep  = keep[i-1];
      assign prev_value = vals[i-1];
    end

    // Last cell is never occupied after a shift
    if (i == CAPACITY - 1) begin : g_last
      assign next_value = vals[i];
    end else begin : g_inner
      assign next_value = vals[i+1];
    end

    depq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IS_MAX     (IS_MAX)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .ins_value  (ins_value),
      .occ        (occ),
      .prev_keep  (prev_keep),
      .prev_value (prev_value),
      .next_value (next_value),
      .keep       (keep[i]),
      .value      (vals[i])
    );
  end

  assign head_value = vals[0];

endmodule

### rtl/double_ended_priority_queue_unit.sv
// Result: registered; the output register is loaded at each input transfer.
// Throughput: one command per cycle when not stalled; both sorted cell chains
// update in the transfer's cycle, so the next command sees new contents at once.
// Reset: clears the held count and the output valid; cell values hold garbage
// until written and are only read below the held count.
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Bounded double-ended priority queue built from two sorted cell chains, one
// ascending and one descending, that hold the same values. The head of each
// chain is the minimum and the maximum; removing from one end of a chain is
// a shift, removing from the other end is a count decrement.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [DATA_WIDTH-1:0]         in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [DATA_WIDTH-1:0]         out_removed_value,
  output logic [1:0]                    out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_count
);
  import depq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                  accept;
  cmd_t                  cmd;
  logic                  empty;
  logic                  full;
  logic [DATA_WIDTH-1:0] min_head;
  logic [DATA_WIDTH-1:0] max_head;
  cell_op_t              min_op;
  cell_op_t              max_op;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  status_t               status_nxt;
  logic [DATA_WIDTH-1:0] removed_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_removed_value_r;
  status_t               out_status_r;
  logic [CNT_W-1:0]      out_count_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_command);
  assign empty    = count_r == '0;
  assign full     = count_r == CNT_W'(CAPACITY);

  always_comb begin
    min_op      = CELL_HOLD;
    max_op      = CELL_HOLD;
    count_nxt   = count_r;
    status_nxt  = STATUS_OK;
    removed_nxt = '0;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          min_op    = CELL_INSERT;
          max_op    = CELL_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE_MIN: begin
        if (empty) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          // min sits at the tail of the max chain: drop it by the count
          min_op      = CELL_SHIFT;
          removed_nxt = min_head;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      CMD_REMOVE_MAX: begin
        if (empty) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          max_op      = CELL_SHIFT;
          removed_nxt = max_head;
          count_nxt   = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase
    if (!accept) begin
      min_op    = CELL_HOLD;
      max_op    = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  depq_chain #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IS_MAX     (1'b0)
  ) u_min_chain (
    .clk        (clk),
    .op         (min_op),
    .ins_value  (in_value),
    .count      (count_r),
    .head_value (min_head)
  );

  depq_chain #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .IS_MAX     (1'b1)
  ) u_max_chain (
    .clk        (clk),
    .op         (max_op),
    .ins_value  (in_value),
    .count      (count_r),
    .head_value (max_head)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result on every input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_removed_value_r <= removed_nxt;
      out_status_r        <= status_nxt;
      out_count_r         <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_value_r;
  assign out_status        = out_status_r;
  assign out_count         = out_count_r;

endmodule

### verif/tb_double_ended_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_priority_queue_unit
// Drives insert, remove-minimum and remove-maximum commands into the queue
// and checks every result against a sorted shadow copy of the contents.
// Covers empty and full flags, duplicates, value extremes, the unused
// command code, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------

// Sorted shadow of the queue contents plus the results still owed by the block
class depq_shadow;

  typedef struct packed {
    logic [31:0]        removed_value;
    depq_pkg::status_t  status;
    logic [6:0]         count;
  } response_t;

  logic [31:0] held_values[$];          // ascending order
  response_t   pending_responses[$];
  int          depth;
  int          error_count;

  function new(int queue_depth);
    depth       = queue_depth;
    error_count = 0;
  endfunction

  function void note_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endfunction

  // Apply one accepted command to the shadow and queue up its result
  function void apply_command(logic [1:0] command, logic [31:0] value);
    response_t rsp;
    int        pos;
    rsp.removed_value = '0;
    rsp.status        = depq_pkg::STATUS_OK;
    case (command)
      depq_pkg::CMD_INSERT: begin
        if (held_values.size() >= depth) begin
          rsp.status = depq_pkg::STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_values.size() && held_values[pos] <= value) pos++;
          held_values.insert(pos, value);
        end
      end
      depq_pkg::CMD_REMOVE_MIN: begin
        if (held_values.size() == 0) rsp.status = depq_pkg::STATUS_EMPTY;
        else rsp.removed_value = held_values.pop_front();
      end
      depq_pkg::CMD_REMOVE_MAX: begin
        if (held_values.size() == 0) rsp.status = depq_pkg::STATUS_EMPTY;
        else rsp.removed_value = held_values.pop_back();
      end
      default: ;  // unused code: no operation
    endcase
    rsp.count = 7'(held_values.size());
    pending_responses.push_back(rsp);
  endfunction

  function void check_response(logic [31:0] removed_value, logic [1:0] status,
                               logic [6:0] count);
    response_t rsp;
    if (pending_responses.size() == 0) begin
      note_error($sformatf("unexpected result: removed %0h status %0d count %0d",
                           removed_value, status, count));
      return;
    end
    rsp = pending_responses.pop_front();
    if (removed_value !== rsp.removed_value)
      note_error($sformatf("removed_value expected %0h actual %0h",
                           rsp.removed_value, removed_value));
    if (status !== rsp.status)
      note_error($sformatf("status expected %0d actual %0d", rsp.status, status));
    if (count !== rsp.count)
      note_error($sformatf("count expected %0d actual %0d", rsp.count, count));
  endfunction

  function int pending();
    return pending_responses.size();
  endfunction

endclass

module tb_double_ended_priority_queue_unit;
  import depq_pkg::*;

  localparam int QUEUE_DEPTH     = 64;
  localparam int VALUE_BITS      = 32;
  localparam int COUNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_command = CMD_INSERT;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_removed_value;
  logic [1:0]            out_status;
  logic [COUNT_BITS-1:0] out_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_requests = 0;
  int hold_off_served = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  depq_shadow sb = new(QUEUE_DEPTH);

  double_ended_priority_queue_unit #(
    .CAPACITY  (QUEUE_DEPTH),
    .DATA_WIDTH(VALUE_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_served + 1;
      hold_off_left   <= HOLD_OFF_CYCLES;
      out_stall       <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor both channels; the watchdog trips when nothing transfers for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_response(out_removed_value, out_status, out_count);
      if (in_valid && !in_stall)
        sb.apply_command(in_command, in_value);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_command(logic [1:0] command, logic [VALUE_BITS-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= command;
    in_value   <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(0, 15);   // force duplicates
      7:          return '0;
      8:          return '1;
      default:    return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  // insert_pct steers the fill level: high values push to full, low ones drain
  task automatic run_segment(int items, int insert_pct);
    logic [1:0] command;
    int         roll;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) command = CMD_UNUSED;
      else if (roll < 3 + insert_pct) command = CMD_INSERT;
      else if ($urandom_range(0, 1) == 0) command = CMD_REMOVE_MIN;
      else command = CMD_REMOVE_MAX;
      send_command(command, random_value());
    end
  endtask

  task automatic run_phase(int sender_idle, int receiver_idle, bit with_hold_off);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    if (with_hold_off) hold_off_requests++;
    run_segment(110, 85);
    run_segment(110, 12);
    run_segment(96, 50);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty removals, unused code, extremes, duplicates
    send_command(CMD_REMOVE_MIN, 32'hFFFF_FFFF);
    send_command(CMD_REMOVE_MAX, 32'h0000_0000);
    send_command(CMD_UNUSED,     32'hFFFF_FFFF);
    send_command(CMD_INSERT,     32'h0000_0000);
    send_command(CMD_INSERT,     32'hFFFF_FFFF);
    send_command(CMD_INSERT,     32'h0000_0005);
    send_command(CMD_INSERT,     32'h0000_0005);
    send_command(CMD_INSERT,     32'h8000_0000);
    send_command(CMD_UNUSED,     32'h0000_0000);
    send_command(CMD_REMOVE_MAX, 32'h0000_0000);
    send_command(CMD_REMOVE_MIN, 32'hFFFF_FFFF);
    send_command(CMD_REMOVE_MIN, 32'h0000_0000);
    send_command(CMD_REMOVE_MAX, 32'h0000_0000);
    send_command(CMD_REMOVE_MAX, 32'h0000_0000);
    send_command(CMD_REMOVE_MIN, 32'h0000_0000);
    send_command(CMD_INSERT,     32'h7FFF_FFFF);
    send_command(CMD_INSERT,     32'h0000_0001);
    send_command(CMD_REMOVE_MIN, 32'h0000_0000);
    send_command(CMD_REMOVE_MIN, 32'h0000_0000);
    send_command(CMD_REMOVE_MAX, 32'h0000_0000);

    run_phase(8, 59, 1'b0);
    run_phase(59, 8, 1'b0);
    run_phase(0, 0, 1'b1);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/depq_pkg.sv
rtl/depq_cell.sv
rtl/depq_chain.sv
rtl/double_ended_priority_queue_unit.sv
verif/tb_double_ended_priority_queue_unit.sv
